// File: src/somf_pkg.sv
// Shared types and constants for the time-server offset median filter.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package somf_pkg;

  // Default window size and fixed protocol constants
  localparam int unsigned WindowDepthDef = 8;
  localparam logic [31:0] EpochGap       = 32'h83AA7E80;  // 1900 -> 1970 in seconds
  localparam logic [7:0]  StratumReset   = 8'd14;
  localparam logic [1:0]  LeapAlarm      = 2'b11;

  // Result status codes
  typedef enum logic [1:0] {
    StOk      = 2'd0,
    StAlarm   = 2'd1,
    StStratum = 2'd2
  } status_e;

  // Controller states
  typedef enum logic [2:0] {
    SIdle,
    SDecide,
    SDelete,
    SInsert,
    SRotate,
    SMedian,
    SDone
  } state_e;

  // Commands from controller to datapath
  typedef struct packed {
    logic load;      // capture a new item
    logic del;       // drop the oldest sample from the sorted chain
    logic ins;       // insert the new sample, shift the age line
    logic rot;       // rotate the sorted chain by one place
    logic med;       // form the debounced median
    logic out_load;  // move the result into the output register
  } cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic reject;    // current item failed the header checks
    logic full;      // window holds WINDOW_DEPTH samples
  } dp_status_t;

endpackage

// File: src/sntp_offset_median_filter.sv
// Steps after an accept: decide, delete (full window only), insert, rotate the chain
// one place per cycle, median, then load the output register; a rejected reply goes
// from decide straight to the output load. One item at a time: the next is taken
// only once the last result has moved into the output register.
// Reset: async active low; window empty, offset zero, max stratum 14.
// No clearing pass; the next item is taken while a result waits in the output register.
`timescale 1ns / 1ps

module sntp_offset_median_filter #(
  parameter int unsigned WINDOW_DEPTH = somf_pkg::WindowDepthDef,
  localparam int unsigned CntW        = $clog2(WINDOW_DEPTH + 1)
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [7:0]          cfg_wdata_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [31:0]         header_word_i,
  input  logic [31:0]         receive_seconds_i,
  input  logic [31:0]         local_seconds_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [1:0]          status_o,
  output logic signed [31:0]  sample_offset_o,
  output logic signed [31:0]  system_offset_o,
  output logic [CntW-1:0]     sample_count_o
);

  import somf_pkg::*;

  localparam int unsigned StepW = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;

  cmd_t              cmd;
  dp_status_t        dp_status;
  logic [StepW-1:0]  rot_step;

  somf_ctrl #(
    .WINDOW_DEPTH(WINDOW_DEPTH)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .out_ready_i (out_ready_i),
    .dp_status_i (dp_status),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .cmd_o       (cmd),
    .rot_step_o  (rot_step)
  );

  somf_datapath #(
    .WINDOW_DEPTH(WINDOW_DEPTH)
  ) u_datapath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_wdata_i       (cfg_wdata_i),
    .header_word_i     (header_word_i),
    .receive_seconds_i (receive_seconds_i),
    .local_seconds_i   (local_seconds_i),
    .cmd_i             (cmd),
    .rot_step_i        (rot_step),
    .dp_status_o       (dp_status),
    .status_o          (status_o),
    .sample_offset_o   (sample_offset_o),
    .system_offset_o   (system_offset_o),
    .sample_count_o    (sample_count_o)
  );

  // One item in flight: busy right after an accept
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("item accepted while another is in flight");

  // Rejected replies carry a zero sample
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o != StOk) |-> (sample_offset_o == 32'sd0))
    else $error("rejected item with nonzero sample offset");

  // Debounce never lets +1 or -1 through
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (system_offset_o != 32'sd1 && system_offset_o != -32'sd1))
    else $error("system offset of one second escaped debounce");

  // Window count never exceeds its depth
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (sample_count_o <= CntW'(WINDOW_DEPTH)))
    else $error("sample count beyond window depth");

endmodule

// File: src/somf_ctrl.sv
// Controller state machine for the offset median filter.
// Depends on somf_pkg; drives somf_datapath through cmd_t and reads dp_status_t.
`timescale 1ns / 1ps

module somf_ctrl #(
  parameter int unsigned WINDOW_DEPTH = somf_pkg::WindowDepthDef,
  localparam int unsigned StepW       = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  input  logic                   out_ready_i,
  input  somf_pkg::dp_status_t   dp_status_i,
  output logic                   in_ready_o,
  output logic                   out_valid_o,
  output somf_pkg::cmd_t         cmd_o,
  output logic [StepW-1:0]       rot_step_o
);

  import somf_pkg::*;

  localparam logic [StepW-1:0] StepLast = StepW'(WINDOW_DEPTH - 1);

  state_e            state_q, state_d;
  logic [StepW-1:0]  step_q, step_d;
  logic              out_valid_q, out_valid_d;
  logic              out_free;

  // Output register can take a result when empty or being drained
  assign out_free = !out_valid_q || out_ready_i;

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      SIdle:   if (in_valid_i) state_d = SDecide;
      SDecide: begin
        priority if (dp_status_i.reject) state_d = SDone;
        else if (dp_status_i.full)       state_d = SDelete;
        else                             state_d = SInsert;
      end
      SDelete: state_d = SInsert;
      SInsert: state_d = SRotate;
      SRotate: if (step_q == StepLast) state_d = SMedian;
      SMedian: state_d = SDone;
      SDone:   if (out_free) state_d = SIdle;
      default: state_d = SIdle;
    endcase
  end

  // Rotation step counter runs once around the chain
  always_comb begin
    step_d = '0;
    if (state_q == SRotate && step_q != StepLast) begin
      step_d = step_q + StepW'(1);
    end
  end

  // Outputs
  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      SIdle: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      SDecide: ;
      SDelete: cmd_o.del = 1'b1;
      SInsert: cmd_o.ins = 1'b1;
      SRotate: cmd_o.rot = 1'b1;
      SMedian: cmd_o.med = 1'b1;
      SDone:   cmd_o.out_load = out_free;
      default: ;
    endcase
  end

  // Result valid flag
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= SIdle;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign rot_step_o  = step_q;

endmodule

// File: src/somf_datapath.sv
// Datapath for the offset median filter: header checks, age line, sorted
// chain, median tap and output register. Depends on somf_pkg.
`timescale 1ns / 1ps

module somf_datapath #(
  parameter int unsigned WINDOW_DEPTH = somf_pkg::WindowDepthDef,
  localparam int unsigned CntW        = $clog2(WINDOW_DEPTH + 1),
  localparam int unsigned StepW       = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [7:0]             cfg_wdata_i,
  input  logic [31:0]            header_word_i,
  input  logic [31:0]            receive_seconds_i,
  input  logic [31:0]            local_seconds_i,
  input  somf_pkg::cmd_t         cmd_i,
  input  logic [StepW-1:0]       rot_step_i,
  output somf_pkg::dp_status_t   dp_status_o,
  output logic [1:0]             status_o,
  output logic signed [31:0]     sample_offset_o,
  output logic signed [31:0]     system_offset_o,
  output logic [CntW-1:0]        sample_count_o
);

  import somf_pkg::*;

  localparam int unsigned D = WINDOW_DEPTH;

  logic [7:0]          max_stratum_q;
  status_e             status_q, status_d;
  logic signed [31:0]  sample_q, sample_d;
  logic [CntW-1:0]     count_q, count_d;
  logic signed [31:0]  line_q  [D];
  logic signed [31:0]  line_d  [D];
  logic signed [31:0]  chain_q [D];
  logic signed [31:0]  chain_d [D];
  logic signed [31:0]  tap0_q, tap1_q;
  logic signed [31:0]  current_q, current_d;
  logic                full;
  logic [CntW-1:0]     keep_len;
  logic [D-1:0]        ge_old;
  logic [D-1:0]        le_new;
  logic [CntW-1:0]     half;
  logic [CntW-1:0]     tgt_wide;
  logic                capture;
  logic signed [32:0]  pair_sum;
  logic signed [32:0]  pair_adj;
  logic signed [31:0]  mean;
  logic [1:0]          leap;
  logic [7:0]          stratum;

  logic [1:0]          out_status_q;
  logic signed [31:0]  out_sample_q, out_system_q;
  logic [CntW-1:0]     out_count_q;

  assign full = (count_q == CntW'(D));

  // Configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_stratum_q <= StratumReset;
    end else if (cfg_we_i) begin
      max_stratum_q <= cfg_wdata_i;
    end
  end

  // Header checks and raw sample; alarm wins over bad stratum
  assign leap    = header_word_i[31:30];
  assign stratum = header_word_i[23:16];

  always_comb begin
    priority if (leap == LeapAlarm)                          status_d = StAlarm;
    else if (stratum == 8'd0 || stratum > max_stratum_q)     status_d = StStratum;
    else                                                     status_d = StOk;
    sample_d = '0;
    if (status_d == StOk) begin
      sample_d = receive_seconds_i - local_seconds_i - EpochGap;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      status_q <= status_d;
      sample_q <= sample_d;
    end
  end

  assign dp_status_o.reject = (status_q != StOk);
  assign dp_status_o.full   = full;

  // Compare masks; both are monotone over the sorted chain
  assign keep_len = full ? CntW'(D - 1) : count_q;

  always_comb begin
    for (int i = 0; i < D; i++) begin
      ge_old[i] = (chain_q[i] >= line_q[D-1]);
      le_new[i] = (CntW'(i) < keep_len) && (chain_q[i] <= sample_q);
    end
  end

  // Median tap position: middle element, or lower middle for an even count
  assign half     = count_q >> 1;
  assign tgt_wide = count_q[0] ? half : half - CntW'(1);
  assign capture  = cmd_i.rot && (rot_step_i == StepW'(tgt_wide));

  // Age line and sorted chain updates
  always_comb begin
    line_d  = line_q;
    chain_d = chain_q;
    count_d = count_q;
    priority if (cmd_i.del) begin
      // remove the first entry not below the oldest sample
      for (int i = 0; i < D - 1; i++) begin
        if (ge_old[i]) chain_d[i] = chain_q[(i + 1) % D];
      end
    end else if (cmd_i.ins) begin
      for (int i = 0; i < D; i++) begin
        if (!le_new[i]) begin
          if (i == 0 || le_new[(i + D - 1) % D]) chain_d[i] = sample_q;
          else                                   chain_d[i] = chain_q[(i + D - 1) % D];
        end
      end
      line_d[0] = sample_q;
      for (int i = 1; i < D; i++) begin
        line_d[i] = line_q[i-1];
      end
      if (!full) count_d = count_q + CntW'(1);
    end else if (cmd_i.rot) begin
      for (int i = 0; i < D; i++) begin
        chain_d[i] = chain_q[(i + 1) % D];
      end
    end else begin
      // hold
    end
  end

  always_ff @(posedge clk_i) begin
    line_q  <= line_d;
    chain_q <= chain_d;
    if (capture) begin
      tap0_q <= chain_q[0];
      tap1_q <= chain_q[1 % D];
    end
  end

  // Mean of the two taps, truncated toward zero, then debounce of +/-1
  assign pair_sum = {tap0_q[31], tap0_q} + {tap1_q[31], tap1_q};
  assign pair_adj = pair_sum + {32'd0, pair_sum[32]};
  assign mean     = pair_adj[32:1];

  always_comb begin
    current_d = count_q[0] ? tap0_q : mean;
    if (current_d == 32'sd1 || current_d == -32'sd1) current_d = '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q   <= '0;
      current_q <= '0;
    end else begin
      count_q <= count_d;
      if (cmd_i.med) current_q <= current_d;
    end
  end

  // Output register
  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_status_q <= status_q;
      out_sample_q <= sample_q;
      out_system_q <= current_q;
      out_count_q  <= count_q;
    end
  end

  assign status_o        = out_status_q;
  assign sample_offset_o = out_sample_q;
  assign system_offset_o = out_system_q;
  assign sample_count_o  = out_count_q;

endmodule

// File: tb/sv/testbench.sv
// Self-checking testbench for sntp_offset_median_filter: a scoreboard class
// predicts status, sample offset, median offset and fill count per reply.
// Depends on somf_pkg and the block's RTL only.
`timescale 1ns / 1ps

module testbench;
  import somf_pkg::*;

  localparam int unsigned Depth      = 8;
  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned DrainWait  = 24;   // extra wait after the last expected result comes back

  // One expected result item
  typedef struct {
    status_e            status;
    logic signed [31:0] sample;
    logic signed [31:0] system;
    logic [3:0]         count;
  } offset_result_t;

  // Predicts the filter and checks result items in order
  class OffsetChecker;
    logic signed [31:0] window [Depth];
    int unsigned        oldest;
    int unsigned        filled;
    logic signed [31:0] offset;
    logic [7:0]         max_stratum;
    offset_result_t     expected_offsets [$];
    int                 errors;
    int                 checked;
    int                 replies;
    int                 limits_used;
    int                 status_seen [3];

    function new();
      oldest      = 0;
      filled      = 0;
      offset      = '0;
      max_stratum = StratumReset;
      errors      = 0;
      checked     = 0;
      replies     = 0;
      limits_used = 1;
      status_seen = '{0, 0, 0};
    endfunction

    function void set_max_stratum(logic [7:0] value);
      max_stratum = value;
      limits_used++;
    endfunction

    function int outstanding();
      return expected_offsets.size();
    endfunction

    // Median of the held samples, even counts averaged toward zero, +/-1 forced to 0
    function logic signed [31:0] debounced_median();
      longint sorted [Depth];
      longint v;
      longint m;
      int     k;
      if (filled == 0) return '0;
      for (int i = 0; i < filled; i++) begin
        v = longint'(window[(oldest + i) % Depth]);
        k = i;
        while (k > 0 && sorted[k-1] > v) begin
          sorted[k] = sorted[k-1];
          k--;
        end
        sorted[k] = v;
      end
      m = sorted[filled/2];
      if (filled % 2 == 0) m = (m + sorted[filled/2 - 1]) / 2;
      if (m == 1 || m == -1) m = 0;
      return m[31:0];
    endfunction

    // An accepted reply: update the window and queue the result it causes
    function void note_reply(logic [31:0] header, logic [31:0] recv, logic [31:0] loc);
      offset_result_t r;
      logic [7:0]     stratum;
      stratum  = header[23:16];
      r.sample = '0;
      if (header[31:30] == LeapAlarm) begin
        r.status = StAlarm;
      end else if (stratum == 8'd0 || stratum > max_stratum) begin
        r.status = StStratum;
      end else begin
        r.status = StOk;
        r.sample = recv - loc - EpochGap;
        if (filled < Depth) begin
          window[(oldest + filled) % Depth] = r.sample;
          filled++;
        end else begin
          window[oldest] = r.sample;
          oldest = (oldest + 1) % Depth;
        end
        offset = debounced_median();
      end
      r.system = offset;
      r.count  = filled[3:0];
      status_seen[r.status]++;
      replies++;
      expected_offsets = {expected_offsets, r};
    endfunction

    function void check_result(logic [1:0] status, logic signed [31:0] sample,
                               logic signed [31:0] system, logic [3:0] count);
      offset_result_t e;
      if (expected_offsets.size() == 0) begin
        $display("%0t: result item with none expected (status %0d, offset %0d)",
                 $time, status, system);
        errors++;
        return;
      end
      e = expected_offsets[0];
      expected_offsets.delete(0);
      checked++;
      if (status !== e.status) begin
        $display("%0t: status expected %0d, got %0d", $time, e.status, status);
        errors++;
      end
      if (sample !== e.sample) begin
        $display("%0t: sample_offset expected %0d, got %0d", $time, e.sample, sample);
        errors++;
      end
      if (system !== e.system) begin
        $display("%0t: system_offset expected %0d, got %0d", $time, e.system, system);
        errors++;
      end
      if (count !== e.count) begin
        $display("%0t: sample_count expected %0d, got %0d", $time, e.count, count);
        errors++;
      end
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni            = 1'b0;
  logic        cfg_we_i          = 1'b0;
  logic [7:0]  cfg_wdata_i       = '0;
  logic        in_valid_i        = 1'b0;
  logic        in_ready_o;
  logic [31:0] header_word_i     = '0;
  logic [31:0] receive_seconds_i = '0;
  logic [31:0] local_seconds_i   = '0;
  logic        out_valid_o;
  logic        out_ready_i       = 1'b0;
  logic [1:0]  status_o;
  logic signed [31:0] sample_offset_o;
  logic signed [31:0] system_offset_o;
  logic [3:0]  sample_count_o;

  OffsetChecker sb;
  int unsigned  cycle_count = 0;
  int unsigned  burst_left  = 0;

  sntp_offset_median_filter #(.WINDOW_DEPTH(Depth)) dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_wdata_i       (cfg_wdata_i),
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .header_word_i     (header_word_i),
    .receive_seconds_i (receive_seconds_i),
    .local_seconds_i   (local_seconds_i),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .status_o          (status_o),
    .sample_offset_o   (sample_offset_o),
    .system_offset_o   (system_offset_o),
    .sample_count_o    (sample_count_o)
  );

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("testbench: errors");
      $finish;
    end
  end

  // Receiver: an 8-bit ready mask, drawn anew each time rx_tick wraps and indexed by
  // its low three bits; bit 0 is always set, so every stall ends when the index returns to 0
  always @(posedge clk_i) begin : rx_pattern
    logic [7:0]  ready_mask;
    logic [4:0]  rx_tick;
    if (!rst_ni) begin
      ready_mask = 8'hFF;
      rx_tick    = '0;
    end
    if (rx_tick == 0)
      ready_mask = ($urandom_range(0, 3) == 0) ? 8'hFF : (8'($urandom) | 8'h01);
    out_ready_i <= ready_mask[rx_tick[2:0]];
    rx_tick++;
  end

  // Monitor: config writes, accepted replies and result items, in edge order
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_we_i) sb.set_max_stratum(cfg_wdata_i);
      if (in_valid_i && in_ready_o)
        sb.note_reply(header_word_i, receive_seconds_i, local_seconds_i);
      if (out_valid_o && out_ready_i)
        sb.check_result(status_o, sample_offset_o, system_offset_o, sample_count_o);
    end
  end

  // Present one reply and hold it until accepted; gaps come between bursts
  task automatic push_reply(logic [31:0] hdr, logic [31:0] recv, logic [31:0] loc);
    header_word_i     <= hdr;
    receive_seconds_i <= recv;
    local_seconds_i   <= loc;
    in_valid_i        <= 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    if (burst_left == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk_i);
      burst_left = $urandom_range(1, 24);
    end else begin
      burst_left--;
    end
  endtask

  // Reply whose offset works out to the given sample
  task automatic send_sample(logic [31:0] hdr, logic signed [31:0] s);
    logic [31:0] loc;
    loc = $urandom;
    push_reply(hdr, loc + EpochGap + s, loc);
  endtask

  function automatic logic [31:0] reply_header(logic [1:0] leap, logic [7:0] stratum);
    return {leap, 6'($urandom), stratum, 16'($urandom)};
  endfunction

  // Stop sending and wait until every expected result has come back
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (sb.outstanding() != 0);
    repeat (DrainWait) @(posedge clk_i);
  endtask

  task automatic write_max_stratum(logic [7:0] value);
    wait_idle();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  // Replies with clustered offsets, mostly accepted, plus alarms and bad strata (all rejected at limit zero)
  task automatic send_random(int unsigned n);
    int unsigned        pick;
    logic [1:0]         leap;
    logic [7:0]         stratum;
    logic [7:0]         lim;
    logic signed [31:0] s;
    for (int unsigned i = 0; i < n; i++) begin
      pick = $urandom_range(0, 99);
      lim  = sb.max_stratum;
      leap = 2'($urandom_range(0, 2));
      if (pick < 8) begin
        leap    = LeapAlarm;
        stratum = 8'($urandom);
      end else if (pick < 16) begin
        if (lim == 8'hFF || $urandom_range(0, 1) == 0) stratum = 8'd0;
        else stratum = 8'($urandom_range(lim + 1, 255));
      end else if (lim == 8'd0) begin
        stratum = 8'($urandom_range(1, 255));
      end else begin
        stratum = 8'($urandom_range(1, lim));
      end
      pick = $urandom_range(0, 99);
      if (pick < 40)      s = $signed($urandom_range(0, 6)) - 3;
      else if (pick < 70) s = $signed($urandom_range(0, 2000)) - 1000;
      else if (pick < 75) s = (pick[0]) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
      else                s = $urandom;
      if ($urandom_range(0, 9) == 0)
        push_reply(reply_header(leap, stratum), $urandom, $urandom);
      else
        send_sample(reply_header(leap, stratum), s);
    end
  endtask

  // Directed replies at the reset stratum limit of 14
  task automatic send_directed();
    logic signed [31:0] tail_samples [10];
    tail_samples = '{-2, -7, -3, -2, -3, -4, -2, -6, 0, 1};
    push_reply(32'h0000_0000, 32'h0000_0000, 32'h0000_0000);  // stratum zero
    push_reply(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);  // alarm, all ones
    push_reply(32'hC000_0000, $urandom, $urandom);            // alarm wins over stratum zero
    push_reply(32'h000F_0000, $urandom, $urandom);            // one over the limit
    send_sample(32'h0001_0000, 1);                            // lone +1 median debounced
    send_sample(32'h400E_FFFF, -1);                           // stratum at the limit
    send_sample(reply_header(2'd2, 8'd7), 3);
    send_sample(reply_header(2'd0, 8'd14), -5);
    push_reply(reply_header(2'd0, 8'd1), 32'h0000_0000, 32'h0000_0000);  // wraps positive
    push_reply(reply_header(2'd1, 8'd2), 32'hFFFF_FFFF, 32'h0000_0000);
    push_reply(reply_header(2'd2, 8'd3), 32'h0000_0000, 32'hFFFF_FFFF);
    send_sample(reply_header(2'd0, 8'd4), 32'sh8000_0000);   // window full after this
    send_sample(reply_header(2'd0, 8'd5), 32'sh7FFF_FFFF);   // oldest dropped
    foreach (tail_samples[i]) send_sample(reply_header(2'd0, 8'd9), tail_samples[i]);
  endtask

  // Main sequence
  initial begin
    sb = new();
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_directed();
    write_max_stratum(8'd1);
    send_random(80);
    write_max_stratum(8'd255);
    send_random(150);
    write_max_stratum(8'd0);
    send_random(30);
    for (int p = 0; p < 4; p++) begin
      write_max_stratum(8'($urandom_range(1, 254)));
      send_random(100);
    end

    wait_idle();
    $display("Sent %0d replies over %0d stratum limits; %0d results checked.",
             sb.replies, sb.limits_used, sb.checked);
    $display("Outcomes: %0d accepted, %0d alarm, %0d stratum rejects.",
             sb.status_seen[StOk], sb.status_seen[StAlarm], sb.status_seen[StStratum]);
    if (sb.errors == 0 && sb.outstanding() == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule
